// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared constants, types and helper functions of the scanner packet decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

  localparam int READINGS_DEF = 4;
  localparam int ANGLE_STEPS  = 360;
  localparam int ANG_OFFSET   = 642;  // 0xA0*4 + 2
  localparam int ANG_BIAS     = ANGLE_STEPS * ((ANG_OFFSET + ANGLE_STEPS - 1) / ANGLE_STEPS);
  localparam int ANG_W        = 11;
  localparam int ANG_OUT_W    = 9;
  localparam int DIST_W       = 14;
  localparam int POS_W        = 32;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int HEAD_W       = 16;
  localparam int XY_W         = 20;
  localparam int Z_W          = 17;
  localparam int PROD_W       = 35;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam logic [XY_W-1:0]   CORDIC_GAIN = XY_W'(39797);
  localparam logic [HEAD_W-1:0] QTR_HALF    = 16'h2000;

  // (ang*65536 + 180) / 360 == (ang*8192 + 22) / 45, by reciprocal 2^28/45
  localparam int               DIV_SHIFT = 28;
  localparam logic [21:0]      DIV_ADD   = 22'((ANGLE_STEPS / 2) >> 3);
  localparam logic [22:0]      DIV_MUL   = 23'd5965233;

  localparam logic [CFG_IDX_W-1:0] REG_POSE_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_HDG = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_ANG_INIT, S_ANG_RED, S_ROT_INIT, S_ROT,
    S_MUL_X, S_MUL_Y, S_PLACE_Y, S_OUT
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic ang_init;
    logic ang_red;
    logic div_init;
    logic rot_init;
    logic rot_step;
    logic mul_x;
    logic mul_y;
    logic place_y;
    logic next_k;
  } cmd_t;

  typedef struct packed {
    logic pkt_ok;
    logic ang_done;
    logic step_done;
    logic last_k;
  } sts_t;

  function automatic logic [13:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [13:0] r;
    case (i)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      4'd14:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  // pose + round(prod / 256), saturated to 32 bits
  function automatic logic [POS_W-1:0] place(input logic signed [POS_W-1:0] pose,
                                             input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W:0]   t;
    logic signed [PROD_W+1:0] v;
    logic [POS_W-1:0]         r;
    t = (PROD_W+1)'(prod) + (PROD_W+1)'(128);
    v = (PROD_W+2)'(pose) + (PROD_W+2)'(t >>> 8);
    if (v > (PROD_W+2)'(64'sd2147483647)) begin
      r = 32'h7fff_ffff;
    end else if (v < -(PROD_W+2)'(64'sd2147483648)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lpd_in_if.sv =====
// ----------------------------------------------------------------------------
// lpd_in_if
// Byte request channel into the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  modport source (output valid, output data_byte, output first, input ready);
  modport sink (input valid, input data_byte, input first, output ready);
endinterface
`default_nettype wire

// ===== rtl/lpd_out_if.sv =====
// ----------------------------------------------------------------------------
// lpd_out_if
// Point request channel out of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface lpd_out_if;
  logic                           valid;
  logic                           ready;
  logic [lpd_pkg::ANG_OUT_W-1:0]  angle_index;
  logic [lpd_pkg::DIST_W-1:0]     distance;
  logic signed [lpd_pkg::POS_W-1:0] pos_x;
  logic signed [lpd_pkg::POS_W-1:0] pos_y;
  logic                           last;
  modport source (output valid, output angle_index, output distance, output pos_x,
                  output pos_y, output last, input ready);
  modport sink (input valid, input angle_index, input distance, input pos_x,
                input pos_y, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/lpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpd_ctrl
// Sequencer: byte intake, then per reading angle, scale, CORDIC, place, emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpd_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  lpd_pkg::sts_t     sts,
  output lpd_pkg::cmd_t     cmd
);
  import lpd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid && sts.pkt_ok) state_nxt = S_ANG_INIT;
      S_ANG_INIT: state_nxt = S_ANG_RED;
      S_ANG_RED:  if (sts.ang_done) state_nxt = S_ROT_INIT;
      S_ROT_INIT: state_nxt = S_ROT;
      S_ROT:      if (sts.step_done) state_nxt = S_MUL_X;
      S_MUL_X:    state_nxt = S_MUL_Y;
      S_MUL_Y:    state_nxt = S_PLACE_Y;
      S_PLACE_Y:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = sts.last_k ? S_IDLE : S_ANG_INIT;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
      end
      S_ANG_INIT: cmd.ang_init = 1'b1;
      S_ANG_RED: begin
        cmd.ang_red  = !sts.ang_done;
        cmd.div_init = sts.ang_done;
      end
      S_ROT_INIT: cmd.rot_init = 1'b1;
      S_ROT:      cmd.rot_step = 1'b1;
      S_MUL_X:    cmd.mul_x = 1'b1;
      S_MUL_Y:    cmd.mul_y = 1'b1;
      S_PLACE_Y:  cmd.place_y = 1'b1;
      S_OUT: begin
        out_valid  = 1'b1;
        cmd.next_k = out_ready && !sts.last_k;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lpd_datapath.sv =====
// ----------------------------------------------------------------------------
// lpd_datapath
// Byte assembly, checksum, reading store, angle reduce and scale, CORDIC, place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpd_datapath #(
  parameter int READINGS_PER_PACKET = lpd_pkg::READINGS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  lpd_pkg::cmd_t                      cmd,
  output lpd_pkg::sts_t                      sts,
  input  wire [7:0]                          in_data_byte,
  input  wire                                in_first,
  input  wire                                cfg_we,
  input  wire [lpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [lpd_pkg::CFG_W-1:0]           cfg_data,
  output logic [lpd_pkg::ANG_OUT_W-1:0]      out_angle_index,
  output logic [lpd_pkg::DIST_W-1:0]         out_distance,
  output logic signed [lpd_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [lpd_pkg::POS_W-1:0]   out_pos_y,
  output logic                               out_last
);
  import lpd_pkg::*;

  localparam int PKT_LEN   = 6 + 4 * READINGS_PER_PACKET;
  localparam int SUM_WORDS = 2 + 2 * READINGS_PER_PACKET;
  localparam int CNT_W     = $clog2(PKT_LEN + 1);
  localparam int SUM_W     = 16 + SUM_WORDS;
  localparam int KW        = (READINGS_PER_PACKET > 1) ? $clog2(READINGS_PER_PACKET) : 1;

  logic signed [POS_W-1:0] pose_x_r, pose_y_r;
  logic [HEAD_W-1:0]       pose_hdg_r;
  logic [CNT_W-1:0]        count_r;
  logic [SUM_W-1:0]        sum_r;
  logic [7:0]              low_r, idx_r;
  logic [15:0]             words_r [READINGS_PER_PACKET];
  logic [KW-1:0]           k_r;
  logic [ANG_W-1:0]        ang_r;
  logic [DIST_W-1:0]       dist_r;
  logic [HEAD_W-1:0]       q_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [XY_W-1:0]  x_r, y_r;
  logic signed [Z_W-1:0]   z_r;
  logic [1:0]              quad_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r;

  logic [CNT_W-1:0]        cnt_eff;
  logic                    active;
  logic [CNT_W-2:0]        widx;
  logic [15:0]             word;
  logic [14:0]             fold;
  logic [21:0]             qnum;
  logic [43:0]             qprod;
  logic [HEAD_W-1:0]       theta, qsum, zraw;
  logic signed [XY_W-1:0]  dx, dy, trig_c, trig_s;
  logic signed [Z_W-1:0]   at;
  logic [15:0]             wsel;

  assign cnt_eff = in_first ? '0 : count_r;
  assign active  = in_first || (count_r < CNT_W'(PKT_LEN));
  assign widx    = cnt_eff[CNT_W-1:1];
  assign word    = {in_data_byte, low_r};
  assign fold    = sum_r[14:0] + 15'(sum_r >> 15);

  assign sts.pkt_ok    = active && cnt_eff[0] && (widx == (CNT_W-1)'(SUM_WORDS))
                         && ({1'b0, fold} == word);
  assign sts.ang_done  = ang_r < ANG_W'(ANGLE_STEPS);
  assign sts.step_done = step_r == STEP_W'(CORDIC_STEPS - 1);
  assign sts.last_k    = k_r == KW'(READINGS_PER_PACKET - 1);

  assign qnum    = {ang_r[8:0], 13'd0} + DIV_ADD;
  assign qprod   = 44'(qnum) * 44'(DIV_MUL);
  assign theta   = pose_hdg_r + q_r;
  assign qsum    = theta + QTR_HALF;
  assign zraw    = theta - {qsum[15:14], 14'd0};
  assign dx      = y_r >>> step_r;
  assign dy      = x_r >>> step_r;
  assign at      = Z_W'({3'b000, atan_lut(step_r)});
  assign wsel    = words_r[k_r];

  always_comb begin
    case (quad_r)
      2'd0:    begin trig_c = x_r;  trig_s = y_r;  end
      2'd1:    begin trig_c = -y_r; trig_s = x_r;  end
      2'd2:    begin trig_c = -x_r; trig_s = -y_r; end
      default: begin trig_c = y_r;  trig_s = -x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r   <= '0;
      pose_y_r   <= '0;
      pose_hdg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POSE_X:   pose_x_r   <= cfg_data;
        REG_POSE_Y:   pose_y_r   <= cfg_data;
        REG_POSE_HDG: pose_hdg_r <= cfg_data[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(PKT_LEN);
      sum_r   <= '0;
      low_r   <= '0;
      idx_r   <= '0;
    end else if (cmd.take_byte && active) begin
      count_r <= cnt_eff + 1'b1;
      if (in_first) sum_r <= '0;
      if (cnt_eff == CNT_W'(1)) idx_r <= in_data_byte;
      if (!cnt_eff[0]) begin
        low_r <= in_data_byte;
      end else if (widx < (CNT_W-1)'(SUM_WORDS)) begin
        sum_r <= {sum_r[SUM_W-2:0], 1'b0} + SUM_W'(word);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && active && cnt_eff[0] && (widx < (CNT_W-1)'(SUM_WORDS))
        && (widx >= (CNT_W-1)'(2)) && !widx[0]) begin
      words_r[KW'((widx - (CNT_W-1)'(2)) >> 1)] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) k_r <= '0;
    else if (cmd.next_k) k_r <= k_r + 1'b1;
    if (cmd.ang_init) begin
      ang_r  <= ANG_W'(int'(idx_r) * 4 + int'(k_r) + ANG_BIAS - ANG_OFFSET);
      dist_r <= (wsel[15:14] != 2'b00) ? '0 : wsel[DIST_W-1:0];
    end else if (cmd.ang_red) begin
      ang_r <= ang_r - ANG_W'(ANGLE_STEPS);
    end
    if (cmd.div_init) q_r <= qprod[DIV_SHIFT +: HEAD_W];
    if (cmd.rot_init) begin
      quad_r <= qsum[15:14];
      z_r    <= Z_W'(signed'(zraw));
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      step_r <= '0;
    end else if (cmd.rot_step) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      step_r <= step_r + 1'b1;
    end
    if (cmd.mul_x) prod_r <= $signed({1'b0, dist_r}) * trig_c;
    if (cmd.mul_y) begin
      prod_r  <= $signed({1'b0, dist_r}) * trig_s;
      pos_x_r <= (dist_r == '0) ? '0 : place(pose_x_r, prod_r);
    end
    if (cmd.place_y) pos_y_r <= (dist_r == '0) ? '0 : place(pose_y_r, prod_r);
  end

  assign out_angle_index = ang_r[ANG_OUT_W-1:0];
  assign out_distance    = dist_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_last        = sts.last_k;

endmodule
`default_nettype wire

// ===== rtl/lidar_packet_decoder_core.sv =====
// ----------------------------------------------------------------------------
// lidar_packet_decoder_core
// Decodes scanner distance packets and turns each reading into a world point.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                     Handshake
// in_chan   in   data_byte[7:0], first                       valid/ready
// out_chan  out  angle_index[8:0], distance[13:0],
//                pos_x[31:0], pos_y[31:0], last              valid/ready
// cfg_*     in   cfg_index[1:0], cfg_data[31:0]              cfg_we
//
// A byte that ends no good packet leaves the decoder in S_IDLE, ready for the next byte.
// A good final byte starts a per-reading sequence, which waits at output on
// out_chan.ready: angle load, angle reduce and scale, CORDIC setup and 16 steps,
// multiply/place (MUL_X, MUL_Y, PLACE_Y), output.
// in_chan.ready is low from the final byte until the last point is taken.
// Synchronous active-low reset returns the decoder to waiting for a first byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lidar_packet_decoder_core #(
  parameter int READINGS_PER_PACKET = lpd_pkg::READINGS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  lpd_in_if.sink                           in_chan,
  lpd_out_if.source                        out_chan,
  input  wire                              cfg_we,
  input  wire [lpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [lpd_pkg::CFG_W-1:0]         cfg_data
);
  import lpd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpd_datapath #(.READINGS_PER_PACKET(READINGS_PER_PACKET)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_byte    (in_chan.data_byte),
    .in_first        (in_chan.first),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_angle_index (out_chan.angle_index),
    .out_distance    (out_chan.distance),
    .out_pos_x       (out_chan.pos_x),
    .out_pos_y       (out_chan.pos_y),
    .out_last        (out_chan.last)
  );

endmodule
`default_nettype wire

// ===== rtl/lpd_checker.sv =====
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level assertions for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lpd_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_ready,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [lpd_pkg::ANG_OUT_W-1:0]    angle_index,
  input wire [lpd_pkg::DIST_W-1:0]       distance,
  input wire [lpd_pkg::POS_W-1:0]        pos_x,
  input wire [lpd_pkg::POS_W-1:0]        pos_y,
  input wire                             last
);
  import lpd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before taken");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("byte intake open during point output");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !out_valid)
    else $error("result after last point of packet");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (distance == '0) |-> (pos_x == '0) && (pos_y == '0))
    else $error("point of zero distance not at origin");

  a_ang: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> angle_index < ANG_OUT_W'(ANGLE_STEPS))
    else $error("angle out of range");

endmodule

bind lidar_packet_decoder_core lpd_checker u_lpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .angle_index (out_chan.angle_index),
  .distance    (out_chan.distance),
  .pos_x       (out_chan.pos_x),
  .pos_y       (out_chan.pos_y),
  .last        (out_chan.last)
);
`default_nettype wire
